>>> rtl/kmx_pkg.sv
`default_nettype none
package kmx_pkg;

  localparam int unsigned ENTRIES  = 64;
  localparam int unsigned IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned EXP_W    = TIME_W + 1;
  localparam int unsigned AGE_W    = 32;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_MISS = 2'd1,
    STS_FULL = 2'd2
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [TIME_W-1:0] now;
  } item_t;

  typedef struct packed {
    status_e          status;
    logic [VAL_W-1:0] found_value;
  } result_t;

  typedef struct packed {
    logic [EXP_W-1:0] expiry;
    logic [VAL_W-1:0] value;
    logic [KEY_W-1:0] key;
  } entry_t;

endpackage
`default_nettype wire

>>> rtl/kmx_ram.sv
`default_nettype none
module kmx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                            clk_i,
  input  wire logic                            we_i,
  input  wire logic                            re_i,
  input  wire logic [$clog2(DEPTH)-1:0]        addr_i,
  input  wire logic [WIDTH-1:0]                wdata_i,
  output logic      [WIDTH-1:0]                rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule
`default_nettype wire

>>> rtl/kmx_scan.sv
`default_nettype none
module kmx_scan (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire kmx_pkg::item_t             item_i,
  input  wire logic [kmx_pkg::AGE_W-1:0]  max_age_i,
  output logic                            ready_o,
  output logic                            res_valid_o,
  input  wire logic                       res_ready_i,
  output kmx_pkg::result_t                res_o
);
  import kmx_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_DECIDE = 3'b100
  } state_e;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_e            state_q, state_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic              issue_q, issue_d;
  logic              rsp_vld_q, rsp_vld_d;
  logic [IDX_W-1:0]  rsp_idx_q, rsp_idx_d;
  logic              match_q, match_d;
  logic [IDX_W-1:0]  match_idx_q, match_idx_d;
  logic [EXP_W-1:0]  match_exp_q, match_exp_d;
  logic [VAL_W-1:0]  match_val_q, match_val_d;
  logic              free_q, free_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;
  item_t             item_q, item_d;
  logic [EXP_W-1:0]  stamp_q, stamp_d;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_addr;
  entry_t            ram_wdata, ram_rdata;
  logic              expired;

  kmx_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign ready_o = (state_q == ST_IDLE);
  assign expired = (match_exp_q != '0) && (match_exp_q < {1'b0, item_q.now});

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    rd_idx_d    = rd_idx_q;
    issue_d     = issue_q;
    rsp_vld_d   = 1'b0;
    rsp_idx_d   = rsp_idx_q;
    match_d     = match_q;
    match_idx_d = match_idx_q;
    match_exp_d = match_exp_q;
    match_val_d = match_val_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    item_d      = item_q;
    stamp_d     = stamp_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = rd_idx_q;
    ram_wdata   = '{expiry: stamp_q, value: item_q.value, key: item_q.key};
    res_valid_o = 1'b0;
    res_o       = '{status: STS_MISS, found_value: '0};

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          item_d   = item_i;
          stamp_d  = (max_age_i != '0) ?
                     ({1'b0, item_i.now} + EXP_W'(max_age_i)) : '0;
          rd_idx_d = '0;
          issue_d  = 1'b1;
          match_d  = 1'b0;
          free_d   = 1'b0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_q) begin
          ram_re    = 1'b1;
          rsp_vld_d = 1'b1;
          rsp_idx_d = rd_idx_q;
          if (rd_idx_q == LAST_IDX) begin
            issue_d = 1'b0;
          end else begin
            rd_idx_d = rd_idx_q + 1'b1;
          end
        end
        if (rsp_vld_q) begin
          if (!match_q && valid_q[rsp_idx_q] && (ram_rdata.key == item_q.key)) begin
            match_d     = 1'b1;
            match_idx_d = rsp_idx_q;
            match_exp_d = ram_rdata.expiry;
            match_val_d = ram_rdata.value;
          end
          if (!free_q && !valid_q[rsp_idx_q]) begin
            free_d     = 1'b1;
            free_idx_d = rsp_idx_q;
          end
          if (rsp_idx_q == LAST_IDX) begin
            state_d = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        res_valid_o = 1'b1;
        case (item_q.op)
          OP_SET: begin
            if (match_q) begin
              ram_addr = match_idx_q;
              res_o.status = STS_OK;
            end else if (free_q) begin
              ram_addr = free_idx_q;
              res_o.status = STS_OK;
            end else begin
              res_o.status = STS_FULL;
            end
            if (res_ready_i && (match_q || free_q)) begin
              ram_we = 1'b1;
              valid_d[ram_addr] = 1'b1;
            end
          end
          OP_GET: begin
            if (match_q && !expired) begin
              res_o.status      = STS_OK;
              res_o.found_value = match_val_q;
            end
          end
          OP_REMOVE: begin
            if (match_q) begin
              res_o.status = STS_OK;
              if (res_ready_i) begin
                valid_d[match_idx_q] = 1'b0;
              end
            end
          end
          default: begin
            res_o.status = STS_MISS;
          end
        endcase
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= '0;
      issue_q   <= 1'b0;
      rsp_vld_q <= 1'b0;
      match_q   <= 1'b0;
      free_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      issue_q   <= issue_d;
      rsp_vld_q <= rsp_vld_d;
      match_q   <= match_d;
      free_q    <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    rsp_idx_q   <= rsp_idx_d;
    match_idx_q <= match_idx_d;
    match_exp_q <= match_exp_d;
    match_val_q <= match_val_d;
    free_idx_q  <= free_idx_d;
    item_q      <= item_d;
    stamp_q     <= stamp_d;
  end

endmodule
`default_nettype wire

>>> rtl/integer_key_map_with_expiry_top.sv
// Integer key map with expiry.
// Input stream: one transfer per operation. tuser carries the operation
// (set, get, remove); tdata carries key, value and current time. A set stamps
// the entry expiry as now plus max_age (zero max_age: never expires).
// Output stream: exactly one transfer per operation, status in tuser and the
// value found by a get hit in tdata (zero otherwise).
// Config channel: writes max_age; always ready, write only while idle.
// Each operation scans all 64 entries through one single-port memory with a
// registered read: the scan state reads the entries in order and compares
// each returned entry, then the decide state does the write-back and offers
// the result. The result is loaded into the output register as the block
// returns to idle, and the next operation is taken in the cycle after that.
// Reset clears all entry valid flags at once (no memory clearing pass) and
// sets max_age to zero.
// A held output register keeps the last result while the receiver stalls; the
// block takes and scans the next operation meanwhile and holds its write-back
// until the output register frees up.
`default_nettype none
module integer_key_map_with_expiry_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [kmx_pkg::AGE_W-1:0]     cfg_data_i,   // max_age
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [111:0]                  s_axis_tdata, // key, value, now
  input  wire logic [1:0]                    s_axis_tuser, // operation
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [kmx_pkg::VAL_W-1:0]          m_axis_tdata, // found_value
  output logic [1:0]                         m_axis_tuser  // status
);
  import kmx_pkg::*;

  logic [AGE_W-1:0] max_age_q;
  logic             out_vld_q, out_vld_d;
  result_t          out_q, out_d;
  item_t            item;
  result_t          res;
  logic             res_valid, res_ready, start;

  assign cfg_ready_o = 1'b1;

  assign item.op    = op_e'(s_axis_tuser);
  assign item.key   = s_axis_tdata[31:0];
  assign item.value = s_axis_tdata[63:32];
  assign item.now   = s_axis_tdata[111:64];

  assign start     = s_axis_tvalid && s_axis_tready;
  assign res_ready = !out_vld_q || m_axis_tready;

  kmx_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .item_i      (item),
    .max_age_i   (max_age_q),
    .ready_o     (s_axis_tready),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_vld_d = 1'b1;
      out_d     = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_age_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q.found_value;
  assign m_axis_tuser  = out_q.status;

endmodule
`default_nettype wire

>>> sim/kmx_map_checker.sv
`timescale 1ns / 100ps
module kmx_map_checker
  import kmx_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic              cfg_ready_i,
  input  wire logic [AGE_W-1:0]  cfg_data_i,
  input  wire logic              in_valid_i,
  input  wire logic              in_ready_i,
  input  wire logic [111:0]      in_data_i,   // key, value, now
  input  wire logic [1:0]        in_user_i,   // operation
  input  wire logic              out_valid_i,
  input  wire logic              out_ready_i,
  input  wire logic [VAL_W-1:0]  out_data_i,  // found_value
  input  wire logic [1:0]        out_user_i,  // status
  output int                     errors_o,
  output int                     waiting_o,
  output int                     full_count_o,
  output int                     expired_count_o
);

  logic             slot_live [ENTRIES];
  logic [KEY_W-1:0] slot_key  [ENTRIES];
  logic [VAL_W-1:0] slot_val  [ENTRIES];
  logic [EXP_W-1:0] slot_exp  [ENTRIES];
  logic [AGE_W-1:0] age;
  result_t          pending_replies [$];
  result_t          due;
  int               full_n;
  int               expired_n;

  assign full_count_o    = full_n;
  assign expired_count_o = expired_n;

  function automatic result_t apply_map_op(input logic [1:0] op, input logic [KEY_W-1:0] key,
                                           input logic [VAL_W-1:0] val,
                                           input logic [TIME_W-1:0] now);
    result_t          r;
    int               hit;
    int               spare;
    logic [EXP_W-1:0] stamp;
    r.status      = STS_MISS;
    r.found_value = '0;
    hit           = -1;
    spare         = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && slot_live[i] && slot_key[i] == key) hit = i;
      if (spare < 0 && !slot_live[i]) spare = i;
    end
    stamp = (age == '0) ? '0 : EXP_W'(now) + EXP_W'(age);
    case (op)
      OP_SET: begin
        if (hit < 0 && spare >= 0) begin
          hit            = spare;
          slot_live[hit] = 1'b1;
          slot_key[hit]  = key;
        end
        if (hit >= 0) begin
          slot_val[hit] = val;
          slot_exp[hit] = stamp;
          r.status      = STS_OK;
        end else begin
          r.status = STS_FULL;
          full_n++;
        end
      end
      OP_GET: begin
        if (hit >= 0) begin
          if (slot_exp[hit] != '0 && slot_exp[hit] < EXP_W'(now)) begin
            expired_n++;
          end else begin
            r.status      = STS_OK;
            r.found_value = slot_val[hit];
          end
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          slot_live[hit] = 1'b0;
          r.status       = STS_OK;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) slot_live[i] = 1'b0;
      age = '0;
      pending_replies.delete();
      full_n    = 0;
      expired_n = 0;
      errors_o  <= 0;
      waiting_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) age = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        pending_replies.push_back(apply_map_op(in_user_i, in_data_i[31:0], in_data_i[63:32],
                                               in_data_i[111:64]));
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: unexpected reply, status %0d value %h", $time, out_user_i, out_data_i);
          errors_o <= errors_o + 1;
        end else begin
          due = pending_replies.pop_front();
          if (out_user_i !== due.status || out_data_i !== due.found_value) begin
            $display("%0t: expected status %0d value %h, got status %0d value %h", $time,
                     due.status, due.found_value, out_user_i, out_data_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      waiting_o <= pending_replies.size();
    end
  end

endmodule

>>> sim/integer_key_map_with_expiry_top_tb.sv
`timescale 1ns / 100ps
module integer_key_map_with_expiry_top_tb;
  import kmx_pkg::*;

  localparam logic [1:0]        OP_IDLE = 2'd3;
  localparam int                LIMIT   = 1_200_000;
  localparam logic [TIME_W-1:0] T_MAX   = 48'hFFFF_FFFF_FFFF;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [AGE_W-1:0] cfg_data_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [111:0]     s_axis_tdata;  // key, value, now
  logic [1:0]       s_axis_tuser;  // operation
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [VAL_W-1:0] m_axis_tdata;  // found_value
  logic [1:0]       m_axis_tuser;  // status

  int errors;
  int waiting;
  int full_seen;
  int expired_seen;
  int items_sent;
  int burst_left;
  int cfg_writes;
  int cycles;
  int stall_mode;
  int stall_timer;

  integer_key_map_with_expiry_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  kmx_map_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_i      (s_axis_tready),
    .in_data_i       (s_axis_tdata),
    .in_user_i       (s_axis_tuser),
    .out_valid_i     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_data_i      (m_axis_tdata),
    .out_user_i      (m_axis_tuser),
    .errors_o        (errors),
    .waiting_o       (waiting),
    .full_count_o    (full_seen),
    .expired_count_o (expired_seen)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("integer_key_map_with_expiry_top: mismatch");
      $finish;
    end
  end

  // receiver: switch stall pattern whenever the stall timer runs out
  initial begin
    m_axis_tready = 1'b0;
    stall_mode    = 0;
    stall_timer   = 0;
  end
  always @(negedge clk_i) begin
    if (stall_timer == 0) begin
      stall_mode  = $urandom_range(0, 3);
      stall_timer = 200;
    end
    stall_timer = stall_timer - 1;
    case (stall_mode)
      0:       m_axis_tready = 1'b1;
      1:       m_axis_tready = $urandom_range(0, 1);
      2:       m_axis_tready = (stall_timer % 16 == 0);
      default: m_axis_tready = ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic push_op(input logic [1:0] op, input logic [KEY_W-1:0] key,
                         input logic [VAL_W-1:0] val, input logic [TIME_W-1:0] now);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 90) : $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {now, val, key};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left = burst_left - 1;
    items_sent = items_sent + 1;
  endtask

  // hold off until every reply is back and the block is idle
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
    while (waiting != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_age(input logic [AGE_W-1:0] age);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = age;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_writes  = cfg_writes + 1;
  endtask

  task automatic run_phase(input int ph);
    logic [KEY_W-1:0]  pool [96];
    logic [KEY_W-1:0]  strays [$];
    logic [31:0]       hi;
    logic [31:0]       lo;
    logic [TIME_W-1:0] clock_t;
    logic [TIME_W-1:0] when;
    logic [KEY_W-1:0]  key;
    logic [1:0]        op;
    int                pool_n;
    int                n;
    int                r;
    settle();
    case (ph % 6)
      0:       write_age('0);
      1:       write_age(32'hFFFF_FFFF);
      2:       write_age($urandom_range(1, 64));
      3:       write_age($urandom);
      4:       write_age(32'd1);
      default: write_age($urandom_range(2, 400));
    endcase
    hi = $urandom;
    lo = $urandom;
    clock_t = (ph % 3 == 0) ? T_MAX - TIME_W'($urandom_range(0, 300)) : {hi[15:0], lo};
    pool_n  = (ph % 3 == 1) ? 90 : $urandom_range(4, 40);
    for (int i = 0; i < pool_n; i++) pool[i] = $urandom;
    if (ph % 3 == 1) begin
      for (int i = 0; i < pool_n; i++) push_op(OP_SET, pool[i], $urandom, clock_t);
    end
    n = $urandom_range(150, 250);
    repeat (n) begin
      r    = $urandom_range(0, 99);
      key  = pool[$urandom_range(0, pool_n - 1)];
      when = clock_t;
      if (r < 40) begin
        op = OP_SET;
      end else if (r < 75) begin
        op = OP_GET;
        if ($urandom_range(0, 7) == 0) key = $urandom;
      end else if (r < 92) begin
        op = OP_REMOVE;
      end else if (r < 95) begin
        op = OP_IDLE;
      end else begin
        op   = 2'($urandom_range(0, 3));
        key  = $urandom;
        hi   = $urandom;
        lo   = $urandom;
        when = {hi[15:0], lo};
        if (op == OP_SET) strays.push_back(key);
      end
      push_op(op, key, $urandom, when);
      clock_t = clock_t + TIME_W'($urandom_range(0, 3));
    end
    for (int i = 0; i < pool_n; i++) push_op(OP_REMOVE, pool[i], $urandom, clock_t);
    foreach (strays[i]) push_op(OP_REMOVE, strays[i], $urandom, clock_t);
  endtask

  initial begin
    int ph;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    items_sent    = 0;
    burst_left    = 0;
    cfg_writes    = 0;
    ph            = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // never-expiring entries with reset max_age
    push_op(OP_GET,    32'h0,         32'h0,         '0);
    push_op(OP_REMOVE, 32'h5,         32'h0,         '0);
    push_op(OP_IDLE,   32'hFFFF_FFFF, 32'hFFFF_FFFF, T_MAX);
    push_op(OP_SET,    32'h0,         32'hFFFF_FFFF, '0);
    push_op(OP_SET,    32'hFFFF_FFFF, 32'h0,         T_MAX);
    push_op(OP_GET,    32'h0,         32'h0,         T_MAX);
    push_op(OP_GET,    32'hFFFF_FFFF, 32'h0,         '0);
    push_op(OP_SET,    32'h0,         32'h1234_5678, 48'd5);
    push_op(OP_GET,    32'h0,         32'h0,         48'd6);
    push_op(OP_REMOVE, 32'hFFFF_FFFF, 32'h0,         48'd7);
    push_op(OP_GET,    32'hFFFF_FFFF, 32'h0,         48'd8);
    push_op(OP_REMOVE, 32'h0,         32'h0,         48'd9);

    // expiry boundary, refresh, removal of an expired entry
    settle();
    write_age(32'd10);
    push_op(OP_SET,    32'h7, 32'hA5A5_5A5A, 48'd100);
    push_op(OP_GET,    32'h7, 32'h0,         48'd110);
    push_op(OP_GET,    32'h7, 32'h0,         48'd111);
    push_op(OP_SET,    32'h7, 32'h0F0F_F0F0, 48'd111);
    push_op(OP_GET,    32'h7, 32'h0,         48'd121);
    push_op(OP_GET,    32'h7, 32'h0,         48'd200);
    push_op(OP_REMOVE, 32'h7, 32'h0,         48'd200);
    push_op(OP_SET,    32'h9, 32'h8000_0001, T_MAX);
    push_op(OP_GET,    32'h9, 32'h0,         T_MAX);
    push_op(OP_REMOVE, 32'h9, 32'h0,         T_MAX);

    while (items_sent < 1650) begin
      run_phase(ph);
      ph = ph + 1;
    end

    settle();
    repeat (80) @(posedge clk_i);
    $display("%0d operations in %0d phases, %0d max_age writes", items_sent, ph, cfg_writes);
    $display("%0d inserts refused on a full table, %0d lookups of expired keys",
             full_seen, expired_seen);
    if (errors == 0) begin
      $display("integer_key_map_with_expiry_top: match");
    end else begin
      $display("integer_key_map_with_expiry_top: mismatch");
    end
    $finish;
  end

endmodule
